FILE: src/assert_macros.svh
// assertion macros shared by the console writer rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int ROW_IN_W   = 5;
  localparam int COL_IN_W   = 7;
  localparam int CUR_CELL_W = 11;
  localparam int CUR_ROW_W  = 5;
  localparam int CUR_COL_W  = 7;
  localparam int CELL_W     = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRINT     = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_FILL_ALL,
    MEM_BLANK_ROW,
    MEM_PUT_CURSOR,
    MEM_GET_READ
  } mem_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_BACK,
    CUR_NEWLINE,
    CUR_LAST_ROW,
    CUR_HOME
  } cur_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic    accept;
    mem_op_t mem_op;
    logic    fill_reset;
    logic    sweep_inc;
    logic    sweep_clr;
    cur_op_t cur_op;
    logic    top_inc;
    logic    top_clr;
    logic    set_scrolled;
    logic    cell_load;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic is_newline;
    logic past_end;
    logic at_zero;
    logic read_in_range;
    logic sweep_last_all;
    logic sweep_last_row;
  } dp_stat_t;

endpackage

FILE: src/tcw_ram.sv
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/tcw_ctrl.sv
// sequencing state machine of the console writer
// depends on tcw_pkg; drives the datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl,
  output logic      busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (stat.sweep_last_all) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_PRINT: begin
            if (stat.past_end)        state_nxt = ST_SCROLL;
            else if (stat.is_newline) state_nxt = ST_RESULT;
            else                      state_nxt = ST_PUT;
          end
          CMD_BACKSPACE: state_nxt = stat.at_zero ? ST_RESULT : ST_PUT;
          CMD_CLEAR:     state_nxt = ST_CLEAR;
          CMD_READ:      state_nxt = stat.read_in_range ? ST_READ_WAIT : ST_RESULT;
          default:       state_nxt = ST_RESULT;
        endcase
      end
      ST_PUT:       state_nxt = ST_RESULT;
      ST_SCROLL: begin
        if (stat.sweep_last_row) state_nxt = stat.is_newline ? ST_RESULT : ST_PUT;
      end
      ST_CLEAR: begin
        if (stat.sweep_last_all) state_nxt = ST_RESULT;
      end
      ST_READ_WAIT: state_nxt = ST_RESULT;
      ST_RESULT:    state_nxt = ST_IDLE;
      default:      state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      ST_INIT: begin
        ctl.mem_op     = MEM_FILL_ALL;
        ctl.fill_reset = 1'b1;
        ctl.sweep_inc  = !stat.sweep_last_all;
        ctl.sweep_clr  = stat.sweep_last_all;
      end
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_PRINT: begin
            if (!stat.past_end && stat.is_newline) ctl.cur_op = CUR_NEWLINE;
          end
          CMD_BACKSPACE: begin
            if (!stat.at_zero) ctl.cur_op = CUR_BACK;
          end
          CMD_READ: begin
            if (stat.read_in_range) ctl.mem_op = MEM_GET_READ;
          end
          default: ctl.cur_op = CUR_HOLD;
        endcase
      end
      ST_PUT: begin
        ctl.mem_op = MEM_PUT_CURSOR;
        ctl.cur_op = (stat.cmd == CMD_PRINT) ? CUR_ADV : CUR_HOLD;
      end
      ST_SCROLL: begin
        ctl.mem_op    = MEM_BLANK_ROW;
        ctl.sweep_inc = !stat.sweep_last_row;
        ctl.sweep_clr = stat.sweep_last_row;
        if (stat.sweep_last_row) begin
          ctl.top_inc      = 1'b1;
          ctl.cur_op       = CUR_LAST_ROW;
          ctl.set_scrolled = 1'b1;
        end
      end
      ST_CLEAR: begin
        ctl.mem_op    = MEM_FILL_ALL;
        ctl.sweep_inc = !stat.sweep_last_all;
        ctl.sweep_clr = stat.sweep_last_all;
        if (stat.sweep_last_all) begin
          ctl.top_clr = 1'b1;
          ctl.cur_op  = CUR_HOME;
        end
      end
      ST_READ_WAIT: ctl.cell_load = 1'b1;
      ST_RESULT:    ctl.out_load  = 1'b1;
      default:      busy = 1'b1;
    endcase
  end

endmodule

FILE: src/tcw_datapath.sv
// cursor, ring top row, sweep counter, cell memory and result registers
// depends on tcw_pkg and tcw_ram; steered by tcw_ctrl
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             ctl,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [ATTR_W-1:0]     in_attribute,
  input  logic [ROW_IN_W-1:0]   in_read_row,
  input  logic [COL_IN_W-1:0]   in_read_col,
  input  logic                  cfg_wr_en,
  input  logic [ATTR_W-1:0]     cfg_wr_data,
  output logic                  out_valid,
  output logic [CUR_CELL_W-1:0] out_cursor_cell,
  output logic [CUR_ROW_W-1:0]  out_cursor_row,
  output logic [CUR_COL_W-1:0]  out_cursor_col,
  output logic [CHAR_W-1:0]     out_cell_char,
  output logic [ATTR_W-1:0]     out_cell_attr,
  output logic                  out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int RIW   = $clog2(ROWS);
  localparam int CIW   = $clog2(COLUMNS);

  localparam logic [AW-1:0]  COLS_A        = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_ALL      = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_COL_A    = AW'(COLUMNS - 1);
  localparam logic [CIW-1:0] LAST_COL      = CIW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROWS_R        = RW'(ROWS);
  localparam logic [RW-1:0]  LAST_ROW_R    = RW'(ROWS - 1);
  localparam logic [RIW-1:0] LAST_TOP      = RIW'(ROWS - 1);
  localparam logic [RIW:0]   ROWS_S        = (RIW + 1)'(ROWS);
  localparam logic [PW-1:0]  COLS_P        = PW'(COLUMNS);
  localparam logic [PW-1:0]  LAST_ROW_CELL = PW'((ROWS - 1) * COLUMNS);

  // latched command fields
  cmd_t                cmd_r;
  logic [CHAR_W-1:0]   char_r;
  logic [ATTR_W-1:0]   attr_r;
  logic [ROW_IN_W-1:0] read_row_r;
  logic [COL_IN_W-1:0] read_col_r;

  logic [ATTR_W-1:0] blank_attr_r;
  logic [RIW-1:0]    top_r, top_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CIW-1:0]    cur_col_r, cur_col_nxt;
  logic [PW-1:0]     cur_cell_r, cur_cell_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic              scrolled_r;
  logic [CHAR_W-1:0] cell_char_r;
  logic [ATTR_W-1:0] cell_attr_r;
  logic              out_valid_r;

  logic [CUR_CELL_W-1:0] out_cell_r;
  logic [CUR_ROW_W-1:0]  out_row_r;
  logic [CUR_COL_W-1:0]  out_col_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic [ATTR_W-1:0]     out_attr_r;
  logic                  out_scrolled_r;

  logic [RIW-1:0]    row_sel;
  logic [CIW-1:0]    col_sel;
  logic [RIW:0]      phys_sum;
  logic [RIW-1:0]    phys_row;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  // status back to the controller
  always_comb begin
    stat.cmd            = cmd_r;
    stat.is_newline     = (char_r == NEWLINE_CODE);
    stat.past_end       = (cur_row_r == ROWS_R);
    stat.at_zero        = (cur_cell_r == '0);
    stat.read_in_range  = (int'(read_row_r) < ROWS) && (int'(read_col_r) < COLUMNS);
    stat.sweep_last_all = (sweep_r == LAST_ALL);
    stat.sweep_last_row = (sweep_r == LAST_COL_A);
  end

  // logical row to physical row through the ring, then to cell address
  always_comb begin
    case (ctl.mem_op)
      MEM_GET_READ: begin
        row_sel = RIW'(read_row_r);
        col_sel = CIW'(read_col_r);
      end
      MEM_BLANK_ROW: begin
        row_sel = '0;
        col_sel = CIW'(sweep_r);
      end
      default: begin
        row_sel = RIW'(cur_row_r);
        col_sel = cur_col_r;
      end
    endcase
    phys_sum  = {1'b0, top_r} + {1'b0, row_sel};
    phys_row  = (phys_sum >= ROWS_S) ? RIW'(phys_sum - ROWS_S) : RIW'(phys_sum);
    cell_addr = AW'(AW'(phys_row) * COLS_A) + AW'(col_sel);
  end

  always_comb begin
    mem_addr  = cell_addr;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (ctl.mem_op)
      MEM_FILL_ALL: begin
        mem_addr  = sweep_r;
        mem_we    = 1'b1;
        mem_wdata = {ctl.fill_reset ? RESET_ATTR : blank_attr_r, BLANK_CHAR};
      end
      MEM_BLANK_ROW: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      MEM_PUT_CURSOR: begin
        mem_we    = 1'b1;
        mem_wdata = (cmd_r == CMD_PRINT) ? {attr_r, char_r} : {blank_attr_r, BLANK_CHAR};
      end
      default: mem_we = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // cursor update
  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cur_cell_nxt = cur_cell_r;
    case (ctl.cur_op)
      CUR_ADV: begin
        cur_cell_nxt = cur_cell_r + PW'(1);
        if (cur_col_r == LAST_COL) begin
          cur_col_nxt = '0;
          cur_row_nxt = cur_row_r + RW'(1);
        end else begin
          cur_col_nxt = cur_col_r + CIW'(1);
        end
      end
      CUR_BACK: begin
        cur_cell_nxt = cur_cell_r - PW'(1);
        if (cur_col_r == '0) begin
          cur_col_nxt = LAST_COL;
          cur_row_nxt = cur_row_r - RW'(1);
        end else begin
          cur_col_nxt = cur_col_r - CIW'(1);
        end
      end
      CUR_NEWLINE: begin
        cur_cell_nxt = cur_cell_r - PW'(cur_col_r) + COLS_P;
        cur_col_nxt  = '0;
        cur_row_nxt  = cur_row_r + RW'(1);
      end
      CUR_LAST_ROW: begin
        cur_cell_nxt = LAST_ROW_CELL;
        cur_col_nxt  = '0;
        cur_row_nxt  = LAST_ROW_R;
      end
      CUR_HOME: begin
        cur_cell_nxt = '0;
        cur_col_nxt  = '0;
        cur_row_nxt  = '0;
      end
      default: cur_cell_nxt = cur_cell_r;
    endcase
  end

  always_comb begin
    top_nxt = top_r;
    if (ctl.top_clr) begin
      top_nxt = '0;
    end else if (ctl.top_inc) begin
      top_nxt = (top_r == LAST_TOP) ? '0 : top_r + RIW'(1);
    end
    sweep_nxt = sweep_r;
    if (ctl.sweep_clr) begin
      sweep_nxt = '0;
    end else if (ctl.sweep_inc) begin
      sweep_nxt = sweep_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_attr_r <= RESET_ATTR;
      top_r        <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      cur_cell_r   <= '0;
      sweep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blank_attr_r <= cfg_wr_data;
      end
      top_r       <= top_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_cell_r  <= cur_cell_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= ctl.out_load;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r       <= cmd_t'(in_cmd);
      char_r      <= in_char_code;
      attr_r      <= in_attribute;
      read_row_r  <= in_read_row;
      read_col_r  <= in_read_col;
      scrolled_r  <= 1'b0;
      cell_char_r <= '0;
      cell_attr_r <= '0;
    end else begin
      if (ctl.set_scrolled) scrolled_r <= 1'b1;
      if (ctl.cell_load) begin
        cell_char_r <= mem_rdata[CHAR_W-1:0];
        cell_attr_r <= mem_rdata[CELL_W-1:CHAR_W];
      end
    end
    if (ctl.out_load) begin
      out_cell_r     <= CUR_CELL_W'(cur_cell_r);
      out_row_r      <= CUR_ROW_W'(cur_row_r);
      out_col_r      <= CUR_COL_W'(cur_col_r);
      out_char_r     <= cell_char_r;
      out_attr_r     <= cell_attr_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_cell = out_cell_r;
  assign out_cursor_row  = out_row_r;
  assign out_cursor_col  = out_col_r;
  assign out_cell_char   = out_char_r;
  assign out_cell_attr   = out_attr_r;
  assign out_scrolled    = out_scrolled_r;

endmodule

FILE: src/text_console_writer_core.sv
// top level of the text console writer: controller plus datapath
// depends on tcw_pkg, tcw_ctrl, tcw_datapath (with tcw_ram) and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - a command is taken at a rising edge with start high and busy low; in_cmd selects
//   print, backspace, clear or read cell, the other in_ ports carry its operands
// - every command gives one result: out_valid is high for exactly one cycle and the
//   out_ ports hold the cursor, the read cell (zero for non-read commands) and the
//   scroll flag; the receiver cannot stall, the result is gone after that cycle
// - from the accepting edge to the out_valid cycle, all work is serial on the one
//   port of the cell memory:
//     newline without scroll, backspace at cell zero, out-of-range read: decode, result
//     print, backspace, in-range read: decode, one cell access, result
//     print that scrolls: one row blanked first (one cell a cycle)
//     clear: whole screen swept (one cell a cycle), then the result
// - busy stays high from acceptance until the result cycle, so one command at a time
// - reset: after rst_n is released a clearing pass over all ROWS*COLUMNS cells (2000 at
//   80x25) fills every cell with char 0, attribute 0x0f while busy is high
// - cfg_wr_en/cfg_wr_data write the blank attribute; use only when idle
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [ATTR_W-1:0]     in_attribute,
  input  logic [ROW_IN_W-1:0]   in_read_row,
  input  logic [COL_IN_W-1:0]   in_read_col,
  // configuration write
  input  logic                  cfg_wr_en,
  input  logic [ATTR_W-1:0]     cfg_wr_data,
  // result channel
  output logic                  out_valid,
  output logic [CUR_CELL_W-1:0] out_cursor_cell,
  output logic [CUR_ROW_W-1:0]  out_cursor_row,
  output logic [CUR_COL_W-1:0]  out_cursor_col,
  output logic [CHAR_W-1:0]     out_cell_char,
  output logic [ATTR_W-1:0]     out_cell_attr,
  output logic                  out_scrolled
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      cmd_transfer;

  // a command transfer completes here
  assign cmd_transfer = start && !busy;

  // sequencer: decides which memory sweep or single access runs each cycle
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // cursor, ring of rows, cell memory and result registers
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_char_code    (in_char_code),
    .in_attribute    (in_attribute),
    .in_read_row     (in_read_row),
    .in_read_col     (in_read_col),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_cursor_cell (out_cursor_cell),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col),
    .out_cell_char   (out_cell_char),
    .out_cell_attr   (out_cell_attr),
    .out_scrolled    (out_scrolled)
  );

  // an accepted command keeps the block busy in the following cycle
  `ASSERT_NEXT(a_accept_then_busy, clk, rst_n, cmd_transfer, busy)
  // one result per command: the strobe is never held high
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // a result only shows once the command has finished
  `ASSERT_IMPLIES(a_result_when_idle, clk, rst_n, out_valid, !busy)

endmodule
